// ----- hdl/rbst_pkg.sv -----
// Package with the payload types and fixed-point constants of the ray-box slab test.
`default_nettype none
package rbst_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int NUM_BITS  = WORD_BITS + 1 + FRAC_BITS;
  localparam int NUM_LANES = 6;

  typedef logic signed [WORD_BITS-1:0] fix_t;

  typedef struct packed {
    fix_t origin_x;
    fix_t origin_y;
    fix_t origin_z;
    fix_t dir_x;
    fix_t dir_y;
    fix_t dir_z;
    fix_t box_min_x;
    fix_t box_min_y;
    fix_t box_min_z;
    fix_t box_max_x;
    fix_t box_max_y;
    fix_t box_max_z;
  } ray_box_in_t;

  typedef struct packed {
    logic hit;
    fix_t entry_distance;
    logic zero_direction;
  } ray_box_out_t;

  typedef struct packed {
    logic [NUM_BITS-1:0]  num;
    logic [WORD_BITS-1:0] den;
    logic [WORD_BITS:0]   rem;
    logic [WORD_BITS-1:0] quo;
    logic                 ovf;
    logic                 neg;
  } div_lane_t;

endpackage
`default_nettype wire

// ----- hdl/ray_box_slab_test_core.sv -----
// Fully pipelined ray versus axis-aligned box slab test in signed fixed point.
// Throughput: one transaction per cycle; the six slab quotients run in a bit-per-stage
// restoring divider pipeline of NUM_BITS stages.
// busy is always low since the receiver cannot stall the pipeline.
// Synchronous reset clears all valid bits; data registers are not reset.
`default_nettype none
module ray_box_slab_test_core
  import rbst_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire ray_box_in_t  ray,
  output logic              done,
  output ray_box_out_t      result
);

  ray_box_in_t ray_q;
  logic        v_a;

  div_lane_t   pipe [0:NUM_BITS][NUM_LANES];
  logic        pv   [0:NUM_BITS];
  logic        pz   [0:NUM_BITS];

  fix_t        t_f [NUM_LANES];
  logic        v_f;
  logic        z_f;

  fix_t        near_n [3];
  fix_t        far_n  [3];
  logic        v_n;
  logic        z_n;

  fix_t        entry;
  fix_t        exit_t;
  logic        v_e;
  logic        z_e;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else begin
      v_a <= start && !busy;
    end
    ray_q <= ray;
  end

  fix_t org_b [3];
  fix_t dir_b [3];
  fix_t lo_b  [3];
  fix_t hi_b  [3];

  always_comb begin
    org_b[0] = ray_q.origin_x;   org_b[1] = ray_q.origin_y;   org_b[2] = ray_q.origin_z;
    dir_b[0] = ray_q.dir_x;      dir_b[1] = ray_q.dir_y;      dir_b[2] = ray_q.dir_z;
    lo_b[0]  = ray_q.box_min_x;  lo_b[1]  = ray_q.box_min_y;  lo_b[2]  = ray_q.box_min_z;
    hi_b[0]  = ray_q.box_max_x;  hi_b[1]  = ray_q.box_max_y;  hi_b[2]  = ray_q.box_max_z;
  end

  div_lane_t lane_b [NUM_LANES];

  always_comb begin
    logic signed [WORD_BITS:0] diff;
    logic [WORD_BITS:0]        dmag;
    logic [WORD_BITS-1:0]      den;
    for (int l = 0; l < NUM_LANES; l++) begin
      if (l < 3) begin
        diff = {lo_b[l % 3][WORD_BITS-1], lo_b[l % 3]} - {org_b[l % 3][WORD_BITS-1], org_b[l % 3]};
      end else begin
        diff = {hi_b[l % 3][WORD_BITS-1], hi_b[l % 3]} - {org_b[l % 3][WORD_BITS-1], org_b[l % 3]};
      end
      dmag = diff[WORD_BITS] ? -diff : diff;
      den  = dir_b[l % 3][WORD_BITS-1] ? -dir_b[l % 3] : dir_b[l % 3];
      lane_b[l].num = {dmag, {FRAC_BITS{1'b0}}};
      lane_b[l].den = den;
      lane_b[l].rem = '0;
      lane_b[l].quo = '0;
      lane_b[l].ovf = 1'b0;
      lane_b[l].neg = diff[WORD_BITS] ^ dir_b[l % 3][WORD_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv[0] <= 1'b0;
    end else begin
      pv[0] <= v_a;
    end
    pz[0] <= (dir_b[0] == '0) || (dir_b[1] == '0) || (dir_b[2] == '0);
    for (int l = 0; l < NUM_LANES; l++) begin
      pipe[0][l] <= lane_b[l];
    end
  end

  for (genvar s = 0; s < NUM_BITS; s++) begin : g_div
    div_lane_t nxt [NUM_LANES];

    always_comb begin
      logic [WORD_BITS:0]   rem_s;
      logic [WORD_BITS+1:0] trial;
      for (int l = 0; l < NUM_LANES; l++) begin
        rem_s = {pipe[s][l].rem[WORD_BITS-1:0], pipe[s][l].num[NUM_BITS-1]};
        trial = {1'b0, rem_s} - {2'b00, pipe[s][l].den};
        nxt[l]     = pipe[s][l];
        nxt[l].num = {pipe[s][l].num[NUM_BITS-2:0], 1'b0};
        nxt[l].ovf = pipe[s][l].ovf | pipe[s][l].quo[WORD_BITS-1];
        if (!trial[WORD_BITS+1]) begin
          nxt[l].rem = trial[WORD_BITS:0];
          nxt[l].quo = {pipe[s][l].quo[WORD_BITS-2:0], 1'b1};
        end else begin
          nxt[l].rem = rem_s;
          nxt[l].quo = {pipe[s][l].quo[WORD_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pv[s+1] <= 1'b0;
      end else begin
        pv[s+1] <= pv[s];
      end
      pz[s+1] <= pz[s];
      for (int l = 0; l < NUM_LANES; l++) begin
        pipe[s+1][l] <= nxt[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_f <= 1'b0;
    end else begin
      v_f <= pv[NUM_BITS];
    end
    z_f <= pz[NUM_BITS];
    for (int l = 0; l < NUM_LANES; l++) begin
      if (pipe[NUM_BITS][l].ovf || pipe[NUM_BITS][l].quo[WORD_BITS-1]) begin
        t_f[l] <= pipe[NUM_BITS][l].neg ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                        : {1'b0, {(WORD_BITS-1){1'b1}}};
      end else begin
        t_f[l] <= pipe[NUM_BITS][l].neg ? -pipe[NUM_BITS][l].quo : pipe[NUM_BITS][l].quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_n <= 1'b0;
    end else begin
      v_n <= v_f;
    end
    z_n <= z_f;
    for (int a = 0; a < 3; a++) begin
      if (t_f[a] < t_f[a+3]) begin
        near_n[a] <= t_f[a];
        far_n[a]  <= t_f[a+3];
      end else begin
        near_n[a] <= t_f[a+3];
        far_n[a]  <= t_f[a];
      end
    end
  end

  fix_t entry_next;
  fix_t exit_next;

  always_comb begin
    entry_next = near_n[0];
    exit_next  = far_n[0];
    for (int a = 1; a < 3; a++) begin
      if (near_n[a] > entry_next) begin
        entry_next = near_n[a];
      end
      if (far_n[a] < exit_next) begin
        exit_next = far_n[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_e <= 1'b0;
    end else begin
      v_e <= v_n;
    end
    z_e    <= z_n;
    entry  <= entry_next;
    exit_t <= exit_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_e;
    end
    if (z_e) begin
      result.hit            <= 1'b0;
      result.entry_distance <= '0;
      result.zero_direction <= 1'b1;
    end else begin
      result.hit            <= (exit_t > entry) && (entry > fix_t'(0));
      result.entry_distance <= entry;
      result.zero_direction <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_done_follows_valid: assert property (@(posedge clk) disable iff (rst)
    v_e |=> done) else $error("result strobe missing after final stage");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    !v_e |=> !done) else $error("result strobe without a transaction");

  a_zero_no_hit: assert property (@(posedge clk) disable iff (rst)
    done && result.zero_direction |-> !result.hit && (result.entry_distance == '0))
    else $error("zero direction result carries a hit or a distance");

  a_hit_positive: assert property (@(posedge clk) disable iff (rst)
    done && result.hit |-> !result.entry_distance[WORD_BITS-1])
    else $error("hit reported with negative entry distance");
`endif

endmodule
`default_nettype wire
